[hw/rtl/pid_motor_drive_assert.svh]
// Assertion macros shared by the PID motor drive RTL.
`ifndef PID_MOTOR_DRIVE_ASSERT_SVH
`define PID_MOTOR_DRIVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pmd_pkg.sv]
// Package for the PID motor drive: payload types, widths, constants and microcode.
package pmd_pkg;

  // Field and datapath widths
  localparam int GAIN_W = 24;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 24;
  localparam int ERR_W  = 24;
  localparam int DIFF_W = 25;
  localparam int SUM_W  = 40;
  localparam int RATE_W = 32;
  localparam int OPA_W  = GAIN_W + 1;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 50;
  localparam int IDX_W  = 3;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 24'd222429;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 24'd445;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 24'd2224292;
  localparam logic [BYTE_W-1:0] DEADBAND_RST = 8'd20;
  localparam logic [BYTE_W-1:0] LIMIT_RST    = 8'd200;
  localparam logic [BYTE_W-1:0] SP_MIN_RST   = 8'd5;
  localparam logic [BYTE_W-1:0] SP_MAX_RST   = 8'd250;

  // Register indexes
  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAIN_P   = 3'd0;
  localparam cfg_idx_t REG_GAIN_I   = 3'd1;
  localparam cfg_idx_t REG_GAIN_D   = 3'd2;
  localparam cfg_idx_t REG_DEADBAND = 3'd3;
  localparam cfg_idx_t REG_LIMIT    = 3'd4;
  localparam cfg_idx_t REG_SP_MIN   = 3'd5;
  localparam cfg_idx_t REG_SP_MAX   = 3'd6;

  // Low-pass coefficients in Q0.16 (0.95 and 0.05) and the rounding half
  localparam logic [GAIN_W-1:0] K_OLD = 24'd62259;
  localparam logic [GAIN_W-1:0] K_NEW = 24'd3277;
  localparam logic signed [ACC_W-1:0] ACC_RND = 50'sd32768;

  // Channel payloads
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [BYTE_W-1:0]       setpoint;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] drive_level;
    logic              drive_right;
  } out_item_t;

  typedef struct packed {
    cfg_idx_t          reg_idx;
    logic [GAIN_W-1:0] wdata;
  } cfg_wr_t;

  // Register file contents
  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [BYTE_W-1:0] deadband_offset;
    logic [BYTE_W-1:0] drive_limit;
    logic [BYTE_W-1:0] setpoint_min;
    logic [BYTE_W-1:0] setpoint_max;
  } cfg_t;

  // Control word fields
  typedef enum logic [2:0] {
    MA_GAIN_P, MA_GAIN_I, MA_GAIN_D, MA_K_OLD, MA_K_NEW
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_ERR, MB_DIFF, MB_RATE, MB_SUM_LO, MB_SUM_HI
  } mul_b_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_RAW, SH_L8, SH_R16, SH_R24
  } acc_sh_e;

  typedef enum logic [1:0] {
    COND_NEVER, COND_NO_IN, COND_OUT_BUSY
  } cond_e;

  // Step counter
  localparam int NUM_STEPS = 9;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_WAIT_IN = 4'd0;
  localparam step_t STEP_INTEG   = 4'd1;
  localparam step_t STEP_FILT_A  = 4'd2;
  localparam step_t STEP_FILT_B  = 4'd3;
  localparam step_t STEP_RATE    = 4'd4;
  localparam step_t STEP_TERM_IH = 4'd5;
  localparam step_t STEP_TERM_P  = 4'd6;
  localparam step_t STEP_TERM_D  = 4'd7;
  localparam step_t STEP_OUT     = 4'd8;

  typedef struct packed {
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    acc_op_e acc_op;
    acc_sh_e acc_sh;
    logic    acc_rnd;
    logic    load_in;
    logic    integ_en;
    logic    rate_en;
    logic    out_en;
    cond_e   cond;
    step_t   jmp_to;
    logic    eop;
  } ctrl_t;

  // Status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '0;
    unique case (step)
      STEP_WAIT_IN: begin
        c.load_in = 1'b1;
        c.cond    = COND_NO_IN;
        c.jmp_to  = STEP_WAIT_IN;
      end
      STEP_INTEG: begin
        c.integ_en = 1'b1;
        c.mul_a    = MA_K_OLD;
        c.mul_b    = MB_RATE;
      end
      STEP_FILT_A: begin
        c.mul_a   = MA_K_NEW;
        c.mul_b   = MB_DIFF;
        c.acc_op  = ACC_LOAD;
        c.acc_sh  = SH_RAW;
        c.acc_rnd = 1'b1;
      end
      STEP_FILT_B: begin
        c.mul_a  = MA_GAIN_I;
        c.mul_b  = MB_SUM_LO;
        c.acc_op = ACC_ADD;
        c.acc_sh = SH_L8;
      end
      STEP_RATE: begin
        c.mul_a   = MA_GAIN_I;
        c.mul_b   = MB_SUM_HI;
        c.acc_op  = ACC_LOAD;
        c.acc_sh  = SH_R16;
        c.rate_en = 1'b1;
      end
      STEP_TERM_IH: begin
        c.mul_a  = MA_GAIN_P;
        c.mul_b  = MB_ERR;
        c.acc_op = ACC_ADD;
        c.acc_sh = SH_L8;
      end
      STEP_TERM_P: begin
        c.mul_a  = MA_GAIN_D;
        c.mul_b  = MB_RATE;
        c.acc_op = ACC_ADD;
        c.acc_sh = SH_R16;
      end
      STEP_TERM_D: begin
        c.acc_op = ACC_ADD;
        c.acc_sh = SH_R24;
      end
      STEP_OUT: begin
        c.out_en = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.jmp_to = STEP_OUT;
        c.eop    = 1'b1;
      end
      default: begin
        c.eop = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/pmd_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
interface pmd_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pmd_cfg_regs.sv]
// Configuration register file of the PID motor drive.
module pmd_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  pmd_pkg::cfg_wr_t wr_data_i,
  output logic             wr_ready_o,
  output pmd_pkg::cfg_t    cfg_o
);
  import pmd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Writes are always taken; unknown indexes are dropped
  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_data_i.reg_idx)
        REG_GAIN_P:   cfg_d.gain_p          = wr_data_i.wdata;
        REG_GAIN_I:   cfg_d.gain_i          = wr_data_i.wdata;
        REG_GAIN_D:   cfg_d.gain_d          = wr_data_i.wdata;
        REG_DEADBAND: cfg_d.deadband_offset = wr_data_i.wdata[BYTE_W-1:0];
        REG_LIMIT:    cfg_d.drive_limit     = wr_data_i.wdata[BYTE_W-1:0];
        REG_SP_MIN:   cfg_d.setpoint_min    = wr_data_i.wdata[BYTE_W-1:0];
        REG_SP_MAX:   cfg_d.setpoint_max    = wr_data_i.wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p          <= GAIN_P_RST;
      cfg_q.gain_i          <= GAIN_I_RST;
      cfg_q.gain_d          <= GAIN_D_RST;
      cfg_q.deadband_offset <= DEADBAND_RST;
      cfg_q.drive_limit     <= LIMIT_RST;
      cfg_q.setpoint_min    <= SP_MIN_RST;
      cfg_q.setpoint_max    <= SP_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/pmd_useq.sv]
// Microcode sequencer: step counter, control store fetch and conditional jumps.
`include "pid_motor_drive_assert.svh"

module pmd_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pmd_pkg::seq_status_t status_i,
  output pmd_pkg::ctrl_t       ctrl_o,
  output logic                 in_ready_o
);
  import pmd_pkg::*;

  step_t step_q;
  step_t step_d;
  ctrl_t word;
  logic  jump;

  // Fetch
  assign word = ucode(step_q);

  // Jump condition
  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_IN:    jump = !status_i.in_valid;
      COND_OUT_BUSY: jump = status_i.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    priority if (jump) begin
      step_d = word.jmp_to;
    end else if (word.eop) begin
      step_d = STEP_WAIT_IN;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT_IN;
    end else begin
      step_q <= step_d;
    end
  end

  // Handshake-bound actions only fire when the step is not waiting
  always_comb begin
    ctrl_o         = word;
    ctrl_o.load_in = word.load_in && !jump;
    ctrl_o.out_en  = word.out_en && !jump;
  end

  assign in_ready_o = (step_q == STEP_WAIT_IN);

  `PMD_ASSERT_NEXT(a_accept_starts, (step_q == STEP_WAIT_IN) && status_i.in_valid, step_q == STEP_INTEG, "accepted transaction did not start the program")
  `PMD_ASSERT_NEXT(a_out_wait_holds, (step_q == STEP_OUT) && status_i.out_busy, step_q == STEP_OUT, "sequencer left output step while result register busy")

endmodule

[hw/rtl/pmd_datapath.sv]
// Datapath: error, integrator, filter and drive terms around one shared multiplier.
`include "pid_motor_drive_assert.svh"

module pmd_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmd_pkg::ctrl_t     ctrl_i,
  input  pmd_pkg::cfg_t      cfg_i,
  input  pmd_pkg::in_item_t  in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output pmd_pkg::out_item_t out_data_o,
  output logic               out_busy_o
);
  import pmd_pkg::*;

  localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

  logic [BYTE_W-1:0]        sp_lo;
  logic [BYTE_W-1:0]        sp_cl;
  logic signed [25:0]       err_wide;
  logic signed [ERR_W-1:0]  err_d, err_q;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [ERR_W-1:0]  last_q;
  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic signed [ACC_W-1:0]  rate_wide;
  logic signed [RATE_W-1:0] rate_d, rate_q;
  logic [GAIN_W-1:0]        op_a;
  logic signed [OPA_W-1:0]  op_a_s;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] shr16, shr24;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic                     neg;
  logic signed [ACC_W-1:0]  abs_drive;
  logic                     mag_hi;
  logic [BYTE_W:0]          lvl_sum;
  out_item_t                out_d, out_q;
  logic                     out_valid_q;

  // Setpoint clamp (upper bound wins) and saturated error
  always_comb begin
    sp_lo    = (in_data_i.setpoint < cfg_i.setpoint_min) ? cfg_i.setpoint_min
                                                         : in_data_i.setpoint;
    sp_cl    = (sp_lo > cfg_i.setpoint_max) ? cfg_i.setpoint_max : sp_lo;
    err_wide = {10'd0, sp_cl, 8'd0} - {{2{in_data_i.position[POS_W-1]}}, in_data_i.position};
    if (err_wide[25:23] == 3'b000 || err_wide[25:23] == 3'b111) begin
      err_d = err_wide[ERR_W-1:0];
    end else begin
      err_d = err_wide[25] ? ERR_MIN : ERR_MAX;
    end
  end

  // Integrator and error difference
  always_comb begin
    sum_wide = {sum_q[SUM_W-1], sum_q} + {{(SUM_W-ERR_W+1){err_q[ERR_W-1]}}, err_q};
    if (sum_wide[SUM_W] == sum_wide[SUM_W-1]) begin
      sum_d = sum_wide[SUM_W-1:0];
    end else begin
      sum_d = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    diff_d = {err_q[ERR_W-1], err_q} - {last_q[ERR_W-1], last_q};
  end

  // Filter output: accumulator over 2^16, saturated to 32 bits
  always_comb begin
    rate_wide = acc_q >>> 16;
    if (acc_q[ACC_W-1:RATE_W+15] == '0 || acc_q[ACC_W-1:RATE_W+15] == '1) begin
      rate_d = rate_wide[RATE_W-1:0];
    end else begin
      rate_d = acc_q[ACC_W-1] ? RATE_MIN : RATE_MAX;
    end
  end

  // Multiplier operand selection
  always_comb begin
    unique case (ctrl_i.mul_a)
      MA_GAIN_P: op_a = cfg_i.gain_p;
      MA_GAIN_I: op_a = cfg_i.gain_i;
      MA_GAIN_D: op_a = cfg_i.gain_d;
      MA_K_OLD:  op_a = K_OLD;
      MA_K_NEW:  op_a = K_NEW;
      default:   op_a = '0;
    endcase
    unique case (ctrl_i.mul_b)
      MB_ERR:    op_b = {{(OPB_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      MB_DIFF:   op_b = {{(OPB_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
      MB_RATE:   op_b = {{(OPB_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
      MB_SUM_LO: op_b = {{(OPB_W-24){1'b0}}, sum_q[23:0]};
      MB_SUM_HI: op_b = {{(OPB_W-(SUM_W-24)){sum_q[SUM_W-1]}}, sum_q[SUM_W-1:24]};
      default:   op_b = '0;
    endcase
  end

  assign op_a_s = {1'b0, op_a};
  assign prod_d = op_a_s * op_b;

  // Product scaling; arithmetic right shifts floor
  assign shr16 = prod_q >>> 16;
  assign shr24 = prod_q >>> 24;

  always_comb begin
    unique case (ctrl_i.acc_sh)
      SH_RAW:  term = prod_q[ACC_W-1:0];
      SH_L8:   term = {prod_q[ACC_W-9:0], 8'd0};
      SH_R16:  term = shr16[ACC_W-1:0];
      SH_R24:  term = shr24[ACC_W-1:0];
      default: term = '0;
    endcase
  end

  // Accumulator
  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = term + (ctrl_i.acc_rnd ? ACC_RND : '0);
      ACC_ADD:  acc_d = acc_q + term;
      default:  acc_d = acc_q;
    endcase
  end

  // Direction, magnitude, deadband and limit
  always_comb begin
    neg       = acc_q[ACC_W-1];
    abs_drive = neg ? -acc_q : acc_q;
    mag_hi    = |abs_drive[ACC_W-1:16];
    lvl_sum   = {1'b0, abs_drive[15:8]} + {1'b0, cfg_i.deadband_offset};
    if (mag_hi || (lvl_sum > {1'b0, cfg_i.drive_limit})) begin
      out_d.drive_level = cfg_i.drive_limit;
    end else begin
      out_d.drive_level = lvl_sum[BYTE_W-1:0];
    end
    out_d.drive_right = !neg;
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (ctrl_i.load_in) begin
      err_q <= err_d;
    end
    if (ctrl_i.integ_en) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.out_en) begin
      out_q <= out_d;
    end
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
      rate_q <= '0;
    end else begin
      if (ctrl_i.integ_en) begin
        sum_q  <= sum_d;
        last_q <= err_q;
      end
      if (ctrl_i.rate_en) begin
        rate_q <= rate_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_busy_o  = out_valid_q && !out_ready_i;

  `PMD_ASSERT_NOW(a_no_overwrite, ctrl_i.out_en, !(out_valid_q && !out_ready_i), "result register overwritten before transaction")
  `PMD_ASSERT_NEXT(a_result_shown, ctrl_i.out_en, out_valid_q, "written result not presented")

endmodule

[hw/rtl/pid_motor_drive.sv]
// PID motor drive top level. Each input transaction (position, setpoint) yields one
// result transaction (drive_level, drive_right). A nine-word microprogram runs every
// update through one shared 25x33-bit multiplier and a 50-bit accumulator: the wait
// step plus eight program steps. A new item is accepted only at the wait step, so the
// block does not take the next item before the result of the previous one is written.
// The result register holds one finished result while the next item is computed; the
// program waits at its last step only while that register is still occupied.
// Configuration writes are taken in any cycle and must only be issued while the block
// is idle; indexes past the last register are ignored. There is no clearing pass after
// reset.
module pid_motor_drive (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmd_chan_if.sink   in_i,
  pmd_chan_if.source out_o,
  pmd_chan_if.sink   cfg_i
);
  import pmd_pkg::*;

  cfg_t        cfg;
  ctrl_t       ctrl;
  seq_status_t status;
  logic        out_busy;

  // Register file
  pmd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // Sequencer status
  assign status.in_valid = in_i.valid;
  assign status.out_busy = out_busy;

  pmd_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_i.ready)
  );

  pmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_busy_o  (out_busy)
  );

endmodule

[dv/tb_pid_motor_drive.sv]
// Self-checking testbench for the PID motor drive: random and directed updates, scoreboarded.
module tb_pid_motor_drive;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  // Filter coefficients (0.95 and 0.05 in Q0.16) and saturation bounds
  localparam longint FLT_OLD  = 62259;
  localparam longint FLT_NEW  = 3277;
  localparam longint FLT_HALF = 32768;
  localparam longint ERR_HI   = 64'sd8388607;
  localparam longint ERR_LO   = -64'sd8388608;
  localparam longint SUM_HI   = 64'sd549755813887;
  localparam longint SUM_LO   = -64'sd549755813888;
  localparam longint RATE_HI  = 64'sd2147483647;
  localparam longint RATE_LO  = -64'sd2147483648;

  // Index past the last register, must be ignored
  localparam cfg_idx_t REG_NONE = 3'd7;

  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pmd_chan_if #(.data_t(in_item_t))  in_ch  ();
  pmd_chan_if #(.data_t(out_item_t)) out_ch ();
  pmd_chan_if #(.data_t(cfg_wr_t))   cfg_ch ();

  pid_motor_drive u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the register file and of the controller state
  cfg_t   cfg_shadow;
  longint integ_sum;
  longint prev_err;
  longint rate_flt;

  in_item_t  in_pend_q[$];
  out_item_t drive_exp_q[$];

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          in_gap_max = 5;
  int          out_gap_max = 5;
  int          out_hold_req = 0;
  int          out_hold_left = 0;
  int unsigned mismatch_cnt = 0;

  // One controller update: returns the drive the block must produce
  function automatic out_item_t pid_update(input in_item_t it);
    longint    pos;
    longint    sp;
    longint    err;
    longint    diff;
    longint    acc;
    longint    drv;
    longint    mag;
    out_item_t res;
    pos = longint'($signed(it.position));
    sp  = longint'(it.setpoint);
    // upper clamp last, so an empty window yields setpoint_max
    if (sp < longint'(cfg_shadow.setpoint_min)) sp = longint'(cfg_shadow.setpoint_min);
    if (sp > longint'(cfg_shadow.setpoint_max)) sp = longint'(cfg_shadow.setpoint_max);

    err = sp * 256 - pos;
    if (err > ERR_HI) err = ERR_HI;
    if (err < ERR_LO) err = ERR_LO;

    integ_sum = integ_sum + err;
    if (integ_sum > SUM_HI) integ_sum = SUM_HI;
    if (integ_sum < SUM_LO) integ_sum = SUM_LO;

    diff = err - prev_err;
    prev_err = err;

    // low-pass on the error change, Q16.16, rounded
    acc = FLT_OLD * rate_flt + FLT_NEW * (diff * 256) + FLT_HALF;
    rate_flt = acc >>> 16;
    if (rate_flt > RATE_HI) rate_flt = RATE_HI;
    if (rate_flt < RATE_LO) rate_flt = RATE_LO;

    // each term floored on its own
    drv = ((longint'(cfg_shadow.gain_i) * integ_sum) >>> 16)
        + ((longint'(cfg_shadow.gain_p) * err) >>> 16)
        + ((longint'(cfg_shadow.gain_d) * rate_flt) >>> 24);

    res.drive_right = (drv >= 0);
    mag = ((drv >= 0) ? drv : -drv) >>> 8;
    mag = mag + longint'(cfg_shadow.deadband_offset);
    if (mag > longint'(cfg_shadow.drive_limit)) mag = longint'(cfg_shadow.drive_limit);
    res.drive_level = mag[7:0];
    return res;
  endfunction

  function automatic void queue_item(input int pos, input int sp);
    in_item_t it;
    it.position = pos[23:0];
    it.setpoint = sp[7:0];
    in_pend_q.push_back(it);
  endfunction

  // Register write over the config channel; shadow follows on the handshake
  task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_idx: idx, wdata: val};
    @(posedge clk_i);
    while (cfg_ch.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_GAIN_P:   cfg_shadow.gain_p = val;
      REG_GAIN_I:   cfg_shadow.gain_i = val;
      REG_GAIN_D:   cfg_shadow.gain_d = val;
      REG_DEADBAND: cfg_shadow.deadband_offset = val[7:0];
      REG_LIMIT:    cfg_shadow.drive_limit = val[7:0];
      REG_SP_MIN:   cfg_shadow.setpoint_min = val[7:0];
      REG_SP_MAX:   cfg_shadow.setpoint_max = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued update was taken and answered, then let the block go idle
  task automatic settle();
    int waited;
    waited = 0;
    do @(posedge clk_i); while (in_pend_q.size() != 0 || in_ch.valid === 1'b1);
    while (drive_exp_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (drive_exp_q.size() != 0) begin
      $error("%0d drive results never arrived", drive_exp_q.size());
      mismatch_cnt++;
      drive_exp_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input driver: one item per transaction, random gap after each
  always @(negedge clk_i) begin : in_drive
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_ch.valid;
    nxt_data  = in_ch.data;
    if (rst_ni) begin
      if (in_ch.valid && in_fire) begin
        nxt_valid = 1'b0;
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (in_pend_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = in_pend_q.pop_front();
        end
      end
    end
    in_ch.valid <= nxt_valid;
    in_ch.data  <= nxt_data;
  end

  // Result receiver: random stall after each transaction, plus requested long hold-off
  always @(negedge clk_i) begin : out_drive
    logic nxt_ready;
    nxt_ready = out_ch.ready;
    if (rst_ni) begin
      if (out_hold_left > 0) begin
        out_hold_left--;
        nxt_ready = 1'b0;
      end else if (out_hold_req > 0) begin
        out_hold_left = out_hold_req - 1;
        out_hold_req = 0;
        nxt_ready = 1'b0;
      end else begin
        if (out_ch.ready && out_fire) out_gap = $urandom_range(0, out_gap_max);
        if (out_gap > 0) begin
          out_gap--;
          nxt_ready = 1'b0;
        end else begin
          nxt_ready = 1'b1;
        end
      end
    end
    out_ch.ready <= nxt_ready;
  end

  // Monitor: check results in order, predict on every accepted update
  always @(posedge clk_i) begin : watch
    out_item_t want;
    in_fire  = (rst_ni === 1'b1) && (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
    out_fire = (rst_ni === 1'b1) && (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
    if (out_fire) begin
      if (drive_exp_q.size() == 0) begin
        $error("drive result with nothing pending: level %0d right %0b",
               out_ch.data.drive_level, out_ch.data.drive_right);
        mismatch_cnt++;
      end else begin
        want = drive_exp_q.pop_front();
        if (out_ch.data.drive_level !== want.drive_level) begin
          $error("drive_level mismatch: expected %0d, actual %0d",
                 want.drive_level, out_ch.data.drive_level);
          mismatch_cnt++;
        end
        if (out_ch.data.drive_right !== want.drive_right) begin
          $error("drive_right mismatch: expected %0b, actual %0b",
                 want.drive_right, out_ch.data.drive_right);
          mismatch_cnt++;
        end
      end
    end
    if (in_fire) drive_exp_q.push_back(pid_update(in_ch.data));
  end

  // Stimulus
  initial begin : stimulus
    int sp;
    int pos;
    int k;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    cfg_shadow = '{gain_p: 24'd222429, gain_i: 24'd445, gain_d: 24'd2224292,
                   deadband_offset: 8'd20, drive_limit: 8'd200,
                   setpoint_min: 8'd5, setpoint_max: 8'd250};
    integ_sum = 0;
    prev_err  = 0;
    rate_flt  = 0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: setpoint clamps, error saturation at the top
    queue_item(0, 0);
    queue_item(0, 255);
    queue_item(128 * 256, 128);
    queue_item(-8388608, 255);
    queue_item(8388607, 0);
    queue_item(8388607, 255);
    queue_item(-8388608, 0);
    queue_item(-1, 1);
    queue_item(100 * 256 + 37, 100);
    settle();

    // only a tiny proportional gain: error of -1 floors to a negative drive
    write_reg(REG_GAIN_P, 24'd1);
    write_reg(REG_GAIN_I, 24'd0);
    write_reg(REG_GAIN_D, 24'd0);
    write_reg(REG_DEADBAND, 24'd0);
    write_reg(REG_LIMIT, 24'd255);
    write_reg(REG_SP_MIN, 24'd0);
    write_reg(REG_SP_MAX, 24'd255);
    queue_item(50 * 256 + 1, 50);
    queue_item(50 * 256, 50);
    queue_item(50 * 256 - 1, 50);
    settle();

    // limit under the deadband, inverted setpoint window, wide data on byte registers
    write_reg(REG_GAIN_P, 24'd0);
    write_reg(REG_DEADBAND, 24'hFFFF00 | 24'd200);
    write_reg(REG_LIMIT, 24'h5A5A00 | 24'd50);
    write_reg(REG_SP_MIN, 24'h123400 | 24'd200);
    write_reg(REG_SP_MAX, 24'hFEDC00 | 24'd100);
    write_reg(REG_NONE, 24'($urandom()));
    queue_item(0, 0);
    queue_item(0, 150);
    queue_item(0, 255);
    queue_item(100 * 256, 100);
    settle();

    // all gains at full scale
    write_reg(REG_GAIN_P, 24'hFFFFFF);
    write_reg(REG_GAIN_I, 24'hFFFFFF);
    write_reg(REG_GAIN_D, 24'hFFFFFF);
    write_reg(REG_DEADBAND, 24'd0);
    write_reg(REG_LIMIT, 24'd255);
    write_reg(REG_SP_MIN, 24'd0);
    write_reg(REG_SP_MAX, 24'd255);
    queue_item(-8388608, 255);
    queue_item(8388607, 0);
    queue_item(0, 0);
    queue_item(8388607, 255);
    settle();

    // random settings, mostly near-target positions
    for (int ph = 0; ph < 5; ph++) begin
      in_gap_max  = (ph == 3) ? 0 : 5;
      out_gap_max = (ph == 3) ? 0 : 5;
      write_reg(REG_GAIN_P, ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 1 << 18)));
      write_reg(REG_GAIN_I, ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 2048)));
      write_reg(REG_GAIN_D, ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 1 << 22)));
      sp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      write_reg(REG_DEADBAND, 24'(($urandom() & 32'hFFFF00) | sp));
      sp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(150, 255);
      write_reg(REG_LIMIT, 24'(($urandom() & 32'hFFFF00) | sp));
      if ($urandom_range(0, 4) == 0) begin
        write_reg(REG_SP_MIN, 24'($urandom()));
        write_reg(REG_SP_MAX, 24'($urandom()));
      end else begin
        write_reg(REG_SP_MIN, 24'($urandom_range(0, 60)));
        write_reg(REG_SP_MAX, 24'($urandom_range(180, 255)));
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_NONE, 24'($urandom()));

      repeat (100) begin
        sp = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) begin
          pos = int'($urandom());
        end else begin
          k = $urandom_range(1, 16);
          pos = sp * 256 + int'($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
        end
        queue_item(pos, sp);
      end
      // receiver stalls long while the sender keeps offering
      if (ph == 2) begin
        in_gap_max = 1;
        out_hold_req = 300;
      end
      settle();
    end

    // hold the largest error so the integrator grows, then swing the error both ways
    in_gap_max  = 0;
    out_gap_max = 0;
    write_reg(REG_GAIN_P, 24'd65535);
    write_reg(REG_GAIN_I, 24'd1);
    write_reg(REG_GAIN_D, 24'd0);
    write_reg(REG_DEADBAND, 24'd0);
    write_reg(REG_LIMIT, 24'd255);
    write_reg(REG_SP_MIN, 24'd0);
    write_reg(REG_SP_MAX, 24'd255);
    repeat (30) queue_item(-8388608, 255);
    repeat (20) begin
      queue_item(8388607, 0);
      queue_item(-8388608, 255);
    end
    settle();

    if (mismatch_cnt == 0) begin
      $display("pid_motor_drive test passed");
    end else begin
      $display("pid_motor_drive test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("pid_motor_drive test failed");
    $finish;
  end

endmodule
